// ===== rtl/aesm_pkg.sv =====
// aesm_pkg: shared types, substitution tables and round functions for the aes modes unit
// no dependencies; imported by aes_block_cipher_modes_unit and the testbench
`timescale 1ns / 1ps
`default_nettype none

package aesm_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_KEY_SIZE = 3'd0;
  localparam logic [2:0] CFG_MODE     = 3'd1;
  localparam logic [2:0] CFG_KEY_0    = 3'd2;
  localparam logic [2:0] CFG_KEY_1    = 3'd3;
  localparam logic [2:0] CFG_KEY_2    = 3'd4;
  localparam logic [2:0] CFG_KEY_3    = 3'd5;
  localparam logic [2:0] CFG_IV_HIGH  = 3'd6;
  localparam logic [2:0] CFG_IV_LOW   = 3'd7;

  // key size codes
  localparam logic [1:0] KEY_192 = 2'd1;
  localparam logic [1:0] KEY_256 = 2'd2;

  // chaining codes, low two bits of the mode register
  localparam logic [1:0] CHAIN_ECB = 2'd0;
  localparam logic [1:0] CHAIN_CBC = 2'd1;
  localparam logic [1:0] CHAIN_CFB = 2'd2;
  localparam logic [1:0] CHAIN_OFB = 2'd3;

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EXPAND = 6'b000010,
    ST_START  = 6'b000100,
    ST_KEY0   = 6'b001000,
    ST_ROUND  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  // forward substitution table, entry 0 in the top byte
  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  // inverse substitution table
  localparam logic [2047:0] INV_SBOX_TBL = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] sbox_f(input logic [7:0] b);
    return SBOX_TBL[2047 - 8 * b -: 8];
  endfunction

  function automatic logic [7:0] inv_sbox_f(input logic [7:0] b);
    return INV_SBOX_TBL[2047 - 8 * b -: 8];
  endfunction

  function automatic logic [7:0] xtime_f(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word_f(input logic [31:0] w);
    return {sbox_f(w[31:24]), sbox_f(w[23:16]), sbox_f(w[15:8]), sbox_f(w[7:0])};
  endfunction

  // one encryption round: sub bytes, shift rows, mix columns unless last, add key
  function automatic logic [127:0] enc_round_f(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic         last);
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, x;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      t[i] = sbox_f(s[127 - 8 * ((i + 4 * (i & 3)) & 15) -: 8]);
    end
    if (!last) begin
      for (int c = 0; c < 16; c += 4) begin
        a0 = t[c]; a1 = t[c + 1]; a2 = t[c + 2]; a3 = t[c + 3];
        x = a0 ^ a1 ^ a2 ^ a3;
        t[c]     = a0 ^ x ^ xtime_f(a0 ^ a1);
        t[c + 1] = a1 ^ x ^ xtime_f(a1 ^ a2);
        t[c + 2] = a2 ^ x ^ xtime_f(a2 ^ a3);
        t[c + 3] = a3 ^ x ^ xtime_f(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127 - 8 * i -: 8] = t[i];
    end
    return r ^ rk;
  endfunction

  // one decryption round: inverse shift and sub, add key, inverse mix unless last
  function automatic logic [127:0] dec_round_f(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic         last);
    logic [7:0]   t [16];
    logic [7:0]   u [16];
    logic [7:0]   a2 [4];
    logic [7:0]   a4 [4];
    logic [7:0]   a8 [4];
    logic [7:0]   m9 [4];
    logic [7:0]   mb [4];
    logic [7:0]   md [4];
    logic [7:0]   me [4];
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      t[(i + 4 * (i & 3)) & 15] = inv_sbox_f(s[127 - 8 * i -: 8]);
    end
    for (int i = 0; i < 16; i++) begin
      t[i] = t[i] ^ rk[127 - 8 * i -: 8];
      u[i] = t[i];
    end
    if (!last) begin
      for (int c = 0; c < 16; c += 4) begin
        for (int k = 0; k < 4; k++) begin
          a2[k] = xtime_f(t[c + k]);
          a4[k] = xtime_f(a2[k]);
          a8[k] = xtime_f(a4[k]);
          m9[k] = a8[k] ^ t[c + k];
          mb[k] = a8[k] ^ a2[k] ^ t[c + k];
          md[k] = a8[k] ^ a4[k] ^ t[c + k];
          me[k] = a8[k] ^ a4[k] ^ a2[k];
        end
        u[c]     = me[0] ^ mb[1] ^ md[2] ^ m9[3];
        u[c + 1] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
        u[c + 2] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
        u[c + 3] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127 - 8 * i -: 8] = u[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/aes_block_cipher_modes_unit.sv =====
// AES ECB/CBC/CFB/OFB block unit: key schedule, round sequencer and chaining
// depends on aesm_pkg
`timescale 1ns / 1ps
`default_nettype none

// One 16-byte block per request, byte 0 in bits 63:56 of block_high_i. A single
// round unit is stepped by a small sequencer, one AES round per cycle; the round
// keys sit in four column memories of 16 rows with registered read. A block goes
// from acceptance to result through a key fetch, the initial key add, Nr rounds
// and a finish state that waits for a free output register. A block marked
// first_block_i expands the key one word per cycle before it starts, writing 44,
// 52 or 60 words, and loads the chain register from the IV when it is accepted.
// in_stall_o is high from acceptance until the result enters the output register;
// a finished result may wait there while the next block is being processed.
// Configuration writes are taken every cycle and must only happen while idle.
module aes_block_cipher_modes_unit
  import aesm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  // input blocks
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] block_high_i,
  input  wire logic [63:0] block_low_i,
  input  wire logic        first_block_i,
  // result blocks
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      result_high_o,
  output logic [63:0]      result_low_o
);

  // configuration registers
  logic [1:0]  key_size_q;
  logic [2:0]  mode_q;
  logic [63:0] key_q [4];
  logic [63:0] iv_q [2];

  // sequencer and datapath registers
  state_e       state_q, state_d;
  logic [127:0] p_q, p_d;
  logic [127:0] blk_q, blk_d;
  logic [127:0] chain_q, chain_d;
  logic [3:0]   r_q, r_d;
  logic [5:0]   i_q, i_d;
  logic [2:0]   j_q, j_d;
  logic [7:0]   rc_q, rc_d;
  logic [31:0]  win_q [8];
  logic [31:0]  win_d [8];
  logic         out_valid_q, out_valid_d;
  logic [127:0] out_q, out_d;

  // round key memory, one bank per column
  logic [31:0]  rk_mem_q [4][16];
  logic [31:0]  rk_rd_q [4];
  logic [127:0] rk_row;
  logic [3:0]   rd_row;
  logic         mem_we;
  logic [31:0]  new_word;

  // derived control
  logic [3:0]   nk, nr;
  logic [5:0]   total;
  logic [1:0]   chaining;
  logic         dec, core_dec;
  logic [127:0] core_in;
  logic [31:0]  temp_word;
  logic [31:0]  key_word;
  logic         in_acc, out_free;

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign result_high_o = out_q[127:64];
  assign result_low_o  = out_q[63:0];
  assign in_acc        = in_valid_i && !in_stall_o;
  assign out_free      = !out_valid_q || !out_stall_i;

  // key length and round count; the unused code behaves as a 128-bit key
  always_comb begin
    priority if (key_size_q == KEY_192) nk = 4'd6;
    else if (key_size_q == KEY_256)     nk = 4'd8;
    else                                nk = 4'd4;
  end
  assign nr       = nk + 4'd6;
  assign total    = {nk, 2'b00} + 6'd28;
  assign chaining = mode_q[1:0];
  assign dec      = mode_q[2];
  // feedback modes always run the cipher forwards
  assign core_dec = dec && (chaining == CHAIN_ECB || chaining == CHAIN_CBC);

  // block that enters the cipher
  always_comb begin
    priority if (chaining == CHAIN_CFB || chaining == CHAIN_OFB) core_in = chain_q;
    else if (chaining == CHAIN_CBC && !dec)                     core_in = p_q ^ chain_q;
    else                                                        core_in = p_q;
  end

  assign rk_row = {rk_rd_q[0], rk_rd_q[1], rk_rd_q[2], rk_rd_q[3]};

  // next schedule word from the sliding window of the last nk words
  assign key_word = i_q[0] ? key_q[i_q[2:1]][31:0] : key_q[i_q[2:1]][63:32];
  always_comb begin
    temp_word = win_q[0];
    priority if (j_q == 3'd0) begin
      temp_word = sub_word_f({win_q[0][23:0], win_q[0][31:24]}) ^ {rc_q, 24'h0};
    end else if (nk == 4'd8 && j_q == 3'd4) begin
      temp_word = sub_word_f(win_q[0]);
    end else begin
      temp_word = win_q[0];
    end
    if ({2'b00, i_q} < {4'b0000, nk}) begin
      new_word = key_word;
    end else begin
      new_word = win_q[nk[2:0] - 3'd1] ^ temp_word;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    blk_d       = blk_q;
    chain_d     = chain_q;
    r_d         = r_q;
    i_d         = i_q;
    j_d         = j_q;
    rc_d        = rc_q;
    win_d       = win_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    rd_row      = r_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          p_d = {block_high_i, block_low_i};
          if (first_block_i) begin
            chain_d = {iv_q[0], iv_q[1]};
            i_d     = '0;
            j_d     = '0;
            rc_d    = 8'h01;
            state_d = ST_EXPAND;
          end else begin
            state_d = ST_START;
          end
        end
      end
      ST_EXPAND: begin
        mem_we   = 1'b1;
        win_d[0] = new_word;
        for (int k = 1; k < 8; k++) begin
          win_d[k] = win_q[k - 1];
        end
        i_d = i_q + 6'd1;
        j_d = (j_q == nk[2:0] - 3'd1) ? 3'd0 : j_q + 3'd1;
        if ({2'b00, i_q} >= {4'b0000, nk} && j_q == 3'd0) begin
          rc_d = xtime_f(rc_q);
        end
        if (i_q == total - 6'd1) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        rd_row  = core_dec ? nr : 4'd0;
        state_d = ST_KEY0;
      end
      ST_KEY0: begin
        blk_d   = core_in ^ rk_row;
        rd_row  = core_dec ? nr - 4'd1 : 4'd1;
        r_d     = rd_row;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (core_dec) begin
          blk_d  = dec_round_f(blk_q, rk_row, r_q == 4'd0);
          rd_row = r_q - 4'd1;
          if (r_q == 4'd0) state_d = ST_FINISH;
        end else begin
          blk_d  = enc_round_f(blk_q, rk_row, r_q == nr);
          rd_row = r_q + 4'd1;
          if (r_q == nr) state_d = ST_FINISH;
        end
        r_d = rd_row;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          unique case (chaining)
            CHAIN_ECB: out_d = blk_q;
            CHAIN_CBC: begin
              if (dec) begin
                out_d   = blk_q ^ chain_q;
                chain_d = p_q;
              end else begin
                out_d   = blk_q;
                chain_d = blk_q;
              end
            end
            CHAIN_CFB: begin
              out_d   = p_q ^ blk_q;
              chain_d = dec ? p_q : (p_q ^ blk_q);
            end
            CHAIN_OFB: begin
              out_d   = p_q ^ blk_q;
              chain_d = blk_q;
            end
            default: out_d = blk_q;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      chain_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      chain_q     <= chain_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    blk_q <= blk_d;
    r_q   <= r_d;
    i_q   <= i_d;
    j_q   <= j_d;
    rc_q  <= rc_d;
    win_q <= win_d;
    out_q <= out_d;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_size_q <= '0;
      mode_q     <= '0;
      key_q      <= '{default: '0};
      iv_q       <= '{default: '0};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_KEY_SIZE: key_size_q <= cfg_data_i[1:0];
        CFG_MODE:     mode_q     <= cfg_data_i[2:0];
        CFG_KEY_0:    key_q[0]   <= cfg_data_i;
        CFG_KEY_1:    key_q[1]   <= cfg_data_i;
        CFG_KEY_2:    key_q[2]   <= cfg_data_i;
        CFG_KEY_3:    key_q[3]   <= cfg_data_i;
        CFG_IV_HIGH:  iv_q[0]    <= cfg_data_i;
        CFG_IV_LOW:   iv_q[1]    <= cfg_data_i;
        default:      mode_q     <= mode_q;
      endcase
    end
  end

  // round key memory: word i goes to column i mod 4, row i div 4
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 4; b++) begin
      if (mem_we && i_q[1:0] == b[1:0]) begin
        rk_mem_q[b][i_q[5:2]] <= new_word;
      end
      rk_rd_q[b] <= rk_mem_q[b][rd_row];
    end
  end

  // checks
  a_first_expands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && first_block_i |=> state_q == ST_EXPAND)
    else $error("first block did not start key expansion");

  a_expand_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXPAND |-> i_q < total)
    else $error("key expansion ran past the schedule length");

  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND |-> r_q <= nr)
    else $error("round counter beyond round count");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result appeared without a finished block");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// testbench for aes_block_cipher_modes_unit: directed table then random messages
// depends on aesm_pkg and the unit itself; results checked against a local AES model
`timescale 1ns / 1ps

module testbench
  import aesm_pkg::*;
();

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  // one row of the directed table
  typedef struct {
    logic [1:0]   ks;
    logic [2:0]   mode;
    logic         first;
    logic [127:0] data;
    logic         known;
    logic [127:0] result;
  } vector_t;

  localparam int WATCHDOG_LIMIT = 400;
  localparam logic [2:0] MODE_DECRYPT = 3'b100;

  // forward substitution, sixteen entries per row
  localparam logic [127:0] FWD_ROWS [16] = '{
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] block_high_i = '0;
  logic [63:0] block_low_i = '0;
  logic        first_block_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] result_high_o;
  logic [63:0] result_low_o;

  aes_block_cipher_modes_unit dut (.*);

  // mirror of the unit's registers and state
  logic [1:0]  key_size_q;
  logic [2:0]  mode_q;
  logic [63:0] key_q [4];
  logic [63:0] iv_q [2];
  logic [31:0] rk_words [60];
  int          rk_filled;
  logic [127:0] chain_q;
  logic [7:0]  inv_tbl [256];

  block_t expected_blocks [$];
  int     errors;
  int     idle_cycles;
  bit     quiet;
  int     out_hold;

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [7:0] sub_byte(input logic [7:0] b);
    return FWD_ROWS[b[7:4]][127 - 8 * b[3:0] -: 8];
  endfunction

  function automatic logic [7:0] dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) r ^= a;
      a = dbl(a);
    end
    return r;
  endfunction

  function automatic int key_words(input logic [1:0] ks);
    return ks == KEY_192 ? 6 : (ks == KEY_256 ? 8 : 4);
  endfunction

  function automatic logic [127:0] round_key(input int r);
    return {rk_words[4 * r], rk_words[4 * r + 1], rk_words[4 * r + 2], rk_words[4 * r + 3]};
  endfunction

  // key schedule from the mirrored key registers
  function automatic void expand_keys();
    int         nk;
    int         total;
    logic [7:0] rcon;
    logic [31:0] t;
    nk = key_words(key_size_q);
    total = 4 * (nk + 7);
    rcon = 8'h01;
    for (int i = 0; i < nk; i++) begin
      rk_words[i] = (i & 1) ? key_q[i >> 1][31:0] : key_q[i >> 1][63:32];
    end
    for (int i = nk; i < total; i++) begin
      t = rk_words[i - 1];
      if (i % nk == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sub_byte(t[31:24]), sub_byte(t[23:16]), sub_byte(t[15:8]), sub_byte(t[7:0])};
        t ^= {rcon, 24'h0};
        rcon = dbl(rcon);
      end else if (nk == 8 && i % nk == 4) begin
        t = {sub_byte(t[31:24]), sub_byte(t[23:16]), sub_byte(t[15:8]), sub_byte(t[7:0])};
      end
      rk_words[i] = rk_words[i - nk] ^ t;
    end
    if (total > rk_filled) rk_filled = total;
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] s);
    int         nr;
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x;
    nr = key_words(key_size_q) + 6;
    s ^= round_key(0);
    for (int r = 1; r <= nr; r++) begin
      for (int i = 0; i < 16; i++) t[i] = sub_byte(s[127 - 8 * ((i + 4 * (i & 3)) & 15) -: 8]);
      if (r != nr) begin
        for (int c = 0; c < 16; c += 4) begin
          a0 = t[c]; a1 = t[c + 1]; a2 = t[c + 2]; a3 = t[c + 3];
          x = a0 ^ a1 ^ a2 ^ a3;
          t[c]     = a0 ^ x ^ dbl(a0 ^ a1);
          t[c + 1] = a1 ^ x ^ dbl(a1 ^ a2);
          t[c + 2] = a2 ^ x ^ dbl(a2 ^ a3);
          t[c + 3] = a3 ^ x ^ dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[127 - 8 * i -: 8] = t[i];
      s ^= round_key(r);
    end
    return s;
  endfunction

  function automatic logic [127:0] aes_decrypt(input logic [127:0] s);
    int         nr;
    logic [7:0] t [16];
    logic [7:0] a, b, c2, d;
    nr = key_words(key_size_q) + 6;
    s ^= round_key(nr);
    for (int r = nr - 1; r >= 0; r--) begin
      for (int i = 0; i < 16; i++) t[(i + 4 * (i & 3)) & 15] = inv_tbl[s[127 - 8 * i -: 8]];
      for (int i = 0; i < 16; i++) s[127 - 8 * i -: 8] = t[i];
      s ^= round_key(r);
      if (r != 0) begin
        for (int c = 0; c < 16; c += 4) begin
          a = s[127 - 8 * c -: 8]; b = s[119 - 8 * c -: 8];
          c2 = s[111 - 8 * c -: 8]; d = s[103 - 8 * c -: 8];
          s[127 - 8 * c -: 8] = gf_mul(a, 8'h0e) ^ gf_mul(b, 8'h0b) ^ gf_mul(c2, 8'h0d)
                                ^ gf_mul(d, 8'h09);
          s[119 - 8 * c -: 8] = gf_mul(a, 8'h09) ^ gf_mul(b, 8'h0e) ^ gf_mul(c2, 8'h0b)
                                ^ gf_mul(d, 8'h0d);
          s[111 - 8 * c -: 8] = gf_mul(a, 8'h0d) ^ gf_mul(b, 8'h09) ^ gf_mul(c2, 8'h0e)
                                ^ gf_mul(d, 8'h0b);
          s[103 - 8 * c -: 8] = gf_mul(a, 8'h0b) ^ gf_mul(b, 8'h0d) ^ gf_mul(c2, 8'h09)
                                ^ gf_mul(d, 8'h0e);
        end
      end
    end
    return s;
  endfunction

  // result of one block under the current mode, updating the chain
  function automatic logic [127:0] cipher_block(input logic [127:0] p, input logic first);
    logic [127:0] o;
    logic [127:0] k;
    logic         dec;
    dec = (mode_q & MODE_DECRYPT) != 0;
    if (first) begin
      expand_keys();
      chain_q = {iv_q[0], iv_q[1]};
    end
    case (mode_q[1:0])
      CHAIN_ECB: begin
        o = dec ? aes_decrypt(p) : aes_encrypt(p);
      end
      CHAIN_CBC: begin
        if (dec) begin
          o = aes_decrypt(p) ^ chain_q;
          chain_q = p;
        end else begin
          o = aes_encrypt(p ^ chain_q);
          chain_q = o;
        end
      end
      CHAIN_CFB: begin
        o = p ^ aes_encrypt(chain_q);
        chain_q = dec ? p : o;
      end
      default: begin
        k = aes_encrypt(chain_q);
        o = p ^ k;
        chain_q = k;
      end
    endcase
    return o;
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // result checking and watchdog
  always @(posedge clk_i) begin
    block_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: result %h %h with nothing expected", $time, result_high_o,
                   result_low_o);
          errors++;
        end else begin
          e = expected_blocks.pop_front();
          if (result_high_o !== e.hi) begin
            $display("%0t: result_high expected %h actual %h", $time, e.hi, result_high_o);
            errors++;
          end
          if (result_low_o !== e.lo) begin
            $display("%0t: result_low expected %h actual %h", $time, e.lo, result_low_o);
            errors++;
          end
        end
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)
          || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("testbench NOT OK");
          $finish;
        end
      end
    end
  end

  // receiver stall bursts
  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_hold = $urandom_range(0, 14);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // drop the request line and wait until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_blocks.size() != 0) @(posedge clk_i);
  endtask

  // register write; valid is left high for a following write
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_KEY_SIZE: key_size_q = data[1:0];
      CFG_MODE:     mode_q = data[2:0];
      CFG_IV_HIGH:  iv_q[0] = data;
      CFG_IV_LOW:   iv_q[1] = data;
      default:      key_q[2'(idx - CFG_KEY_0)] = data;
    endcase
  endtask

  task automatic end_writes();
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one request, at random with an idle gap ahead of it outside the quiet phases
  task automatic send_block(input logic [127:0] data, input logic first,
                            input logic known, input logic [127:0] result);
    logic [127:0] o;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    block_high_i <= data[127:64];
    block_low_i <= data[63:0];
    first_block_i <= first;
    do @(posedge clk_i); while (in_stall_o);
    o = cipher_block(data, first);
    expected_blocks.push_back(known ? result : o);
  endtask

  localparam logic [127:0] FIPS_PT  = 128'h00112233445566778899aabbccddeeff;
  localparam logic [127:0] FIPS_128 = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
  localparam logic [127:0] FIPS_192 = 128'hdda97ca4864cdfe06eaf70a0ec0d7191;
  localparam logic [127:0] FIPS_256 = 128'h8ea2b7ca516745bfeafc49904b496089;

  // directed table: known answers first, then every mode against the local model
  vector_t directed [] = '{
    '{2'd0, 3'd0, 1'b1, FIPS_PT,  1'b1, FIPS_128},
    '{2'd0, 3'd4, 1'b1, FIPS_128, 1'b1, FIPS_PT},
    '{2'd1, 3'd0, 1'b1, FIPS_PT,  1'b1, FIPS_192},
    '{2'd1, 3'd4, 1'b1, FIPS_192, 1'b1, FIPS_PT},
    '{2'd2, 3'd0, 1'b1, FIPS_PT,  1'b1, FIPS_256},
    '{2'd2, 3'd4, 1'b1, FIPS_256, 1'b1, FIPS_PT},
    // key size three behaves as a 128-bit key
    '{2'd3, 3'd0, 1'b1, FIPS_PT,  1'b1, FIPS_128},
    // longer key size over a shorter expansion: rounds from the register
    '{2'd2, 3'd0, 1'b0, FIPS_PT,  1'b0, '0},
    '{2'd0, 3'd0, 1'b1, '0,       1'b0, '0},
    '{2'd0, 3'd0, 1'b0, '1,       1'b0, '0},
    '{2'd0, 3'd1, 1'b1, '0,       1'b0, '0},
    '{2'd0, 3'd1, 1'b0, '1,       1'b0, '0},
    '{2'd0, 3'd5, 1'b1, '1,       1'b0, '0},
    '{2'd0, 3'd5, 1'b0, FIPS_PT,  1'b0, '0},
    '{2'd1, 3'd2, 1'b1, FIPS_PT,  1'b0, '0},
    '{2'd1, 3'd2, 1'b0, '0,       1'b0, '0},
    '{2'd1, 3'd6, 1'b1, '1,       1'b0, '0},
    '{2'd1, 3'd6, 1'b0, FIPS_PT,  1'b0, '0},
    '{2'd2, 3'd3, 1'b1, '0,       1'b0, '0},
    '{2'd2, 3'd3, 1'b0, '1,       1'b0, '0},
    '{2'd2, 3'd7, 1'b1, FIPS_PT,  1'b0, '0},
    // ecb after a chained block leaves the chain alone
    '{2'd2, 3'd4, 1'b0, FIPS_256, 1'b0, '0},
    '{2'd2, 3'd7, 1'b0, '0,       1'b0, '0}
  };

  // stimulus
  initial begin
    int          sent;
    int          len;
    bit          keep_chain;
    logic [2:0]  order [8];
    logic [1:0]  ks;
    for (int i = 0; i < 256; i++) inv_tbl[sub_byte(8'(i))] = 8'(i);
    key_size_q = '0;
    mode_q = '0;
    key_q = '{default: '0};
    iv_q = '{default: '0};
    rk_filled = 0;
    chain_q = '0;
    errors = 0;
    idle_cycles = 0;
    quiet = 0;
    out_hold = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_KEY_0, 64'h0001020304050607);
    write_reg(CFG_KEY_1, 64'h08090a0b0c0d0e0f);
    write_reg(CFG_KEY_2, 64'h1011121314151617);
    write_reg(CFG_KEY_3, 64'h18191a1b1c1d1e1f);
    write_reg(CFG_IV_HIGH, 64'hf0f1f2f3f4f5f6f7);
    write_reg(CFG_IV_LOW, 64'hf8f9fafbfcfdfeff);
    write_reg(CFG_KEY_SIZE, '0);
    write_reg(CFG_MODE, '0);
    end_writes();

    foreach (directed[i]) begin
      if (directed[i].ks != key_size_q || directed[i].mode != mode_q) begin
        drain();
        write_reg(CFG_KEY_SIZE, {$urandom, $urandom} & ~64'h3 | directed[i].ks);
        write_reg(CFG_MODE, {$urandom, $urandom} & ~64'h7 | directed[i].mode);
        end_writes();
      end
      send_block(directed[i].data, directed[i].first, directed[i].known, directed[i].result);
    end

    // random phases of messages
    for (int ph = 0; ph < 16; ph++) begin
      drain();
      quiet = ph >= 14;
      keep_chain = ph > 0 && $urandom_range(0, 3) == 0;
      if (keep_chain) begin
        ks = 2'($urandom_range(0, 3));
        if (4 * (key_words(ks) + 7) <= rk_filled) write_reg(CFG_KEY_SIZE, 64'(ks));
        write_reg(CFG_MODE, 64'($urandom_range(0, 7)));
      end else begin
        order = '{CFG_KEY_SIZE, CFG_MODE, CFG_KEY_0, CFG_KEY_1, CFG_KEY_2, CFG_KEY_3,
                  CFG_IV_HIGH, CFG_IV_LOW};
        order.shuffle();
        foreach (order[j]) begin
          if (order[j] == CFG_KEY_SIZE) write_reg(order[j], {$urandom, $urandom});
          else if (order[j] == CFG_MODE) write_reg(order[j], {$urandom, $urandom});
          else write_reg(order[j], rand64());
        end
      end
      end_writes();
      sent = 0;
      while (sent < 100) begin
        len = $urandom_range(1, 12);
        for (int j = 0; j < len; j++) begin
          // a stray first flag inside a message restarts the chain
          send_block({rand64(), rand64()},
                     (j == 0 && !keep_chain) || $urandom_range(0, 19) == 0, 1'b0, '0);
          keep_chain = 0;
          sent++;
        end
        // hold off until the unit has fully drained
        if (ph == 5 && sent >= 50 && sent < 62) drain();
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
